FILE: sv/pirc_pkg.sv
`default_nettype none

package pirc_pkg;

  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned REL_W       = COORD_WIDTH + 1;
  localparam int unsigned PROD_W      = 2 * REL_W;
  localparam int unsigned FIFO_DEPTH  = 2;
  localparam int unsigned PTR_W       = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W       = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    CLS_FIRST,
    CLS_NONE,
    CLS_CROSS,
    CLS_TEST
  } edge_cls_e;

  typedef struct packed {
    edge_cls_e               cls;
    logic                    dy_pos;
    logic                    last;
    logic signed [REL_W-1:0] x1;
    logic signed [REL_W-1:0] y1;
    logic signed [REL_W-1:0] x2;
    logic signed [REL_W-1:0] y2;
  } edge_req_t;

endpackage

`default_nettype wire

FILE: sv/pirc_front.sv
`default_nettype none

module pirc_front (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  accept_i,
  input  wire logic signed [pirc_pkg::COORD_WIDTH-1:0] vertex_x_i,
  input  wire logic signed [pirc_pkg::COORD_WIDTH-1:0] vertex_y_i,
  input  wire logic signed [pirc_pkg::COORD_WIDTH-1:0] query_x_i,
  input  wire logic signed [pirc_pkg::COORD_WIDTH-1:0] query_y_i,
  input  wire logic                                  first_vertex_i,
  input  wire logic                                  last_vertex_i,
  output logic                                       push_o,
  output pirc_pkg::edge_req_t                        push_req_o
);

  localparam int unsigned W = pirc_pkg::COORD_WIDTH;
  localparam int unsigned R = pirc_pkg::REL_W;

  logic signed [W-1:0] prev_x_q, prev_x_d;
  logic signed [W-1:0] prev_y_q, prev_y_d;
  logic                ring_open_q, ring_open_d;

  logic signed [R-1:0] x1, y1, x2, y2;
  logic                y1_pos, y1_neg, y1_zero, y2_pos, y2_neg, y2_zero;
  logic                x1_pos, x2_pos;
  logic                keep;
  pirc_pkg::edge_cls_e edge_cls;

  assign x1 = {prev_x_q[W-1], prev_x_q} - {query_x_i[W-1], query_x_i};
  assign y1 = {prev_y_q[W-1], prev_y_q} - {query_y_i[W-1], query_y_i};
  assign x2 = {vertex_x_i[W-1], vertex_x_i} - {query_x_i[W-1], query_x_i};
  assign y2 = {vertex_y_i[W-1], vertex_y_i} - {query_y_i[W-1], query_y_i};

  assign y1_neg  = y1[R-1];
  assign y1_zero = (y1 == '0);
  assign y1_pos  = !y1_neg && !y1_zero;
  assign y2_neg  = y2[R-1];
  assign y2_zero = (y2 == '0);
  assign y2_pos  = !y2_neg && !y2_zero;
  assign x1_pos  = !x1[R-1] && (x1 != '0);
  assign x2_pos  = !x2[R-1] && (x2 != '0);

  // classify the edge from signs alone where possible
  always_comb begin
    if (first_vertex_i) begin
      edge_cls = pirc_pkg::CLS_FIRST;
    end else if ((y1_pos && y2_pos) || (y1_neg && y2_neg) ||
                 (y1_zero && y2_pos) || (y2_zero && y1_pos)) begin
      edge_cls = pirc_pkg::CLS_NONE;
    end else if (x1_pos && x2_pos) begin
      edge_cls = pirc_pkg::CLS_CROSS;
    end else if (y1 == y2) begin
      edge_cls = pirc_pkg::CLS_NONE;
    end else begin
      edge_cls = pirc_pkg::CLS_TEST;
    end
  end

  assign keep   = first_vertex_i || ring_open_q;
  assign push_o = accept_i && keep;

  always_comb begin
    push_req_o.cls    = edge_cls;
    push_req_o.dy_pos = (y2 > y1);
    push_req_o.last   = last_vertex_i;
    push_req_o.x1     = x1;
    push_req_o.y1     = y1;
    push_req_o.x2     = x2;
    push_req_o.y2     = y2;
  end

  always_comb begin
    prev_x_d    = prev_x_q;
    prev_y_d    = prev_y_q;
    ring_open_d = ring_open_q;
    if (accept_i && keep) begin
      prev_x_d    = vertex_x_i;
      prev_y_d    = vertex_y_i;
      ring_open_d = !last_vertex_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      ring_open_q <= 1'b0;
    end else begin
      prev_x_q    <= prev_x_d;
      prev_y_q    <= prev_y_d;
      ring_open_q <= ring_open_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/pirc_fifo.sv
`default_nettype none

module pirc_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire pirc_pkg::edge_req_t  push_req_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output logic                      valid_o,
  output pirc_pkg::edge_req_t       pop_req_o
);

  localparam int unsigned D  = pirc_pkg::FIFO_DEPTH;
  localparam int unsigned PW = pirc_pkg::PTR_W;
  localparam int unsigned CW = pirc_pkg::CNT_W;

  pirc_pkg::edge_req_t mem_q [D];
  logic [PW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]       count_q, count_d;
  logic                do_push, do_pop;

  assign full_o    = (count_q == CW'(D));
  assign valid_o   = (count_q != '0);
  assign pop_req_o = mem_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + PW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(D))
    else $error("queue count beyond depth");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("request pushed into full queue");
`endif

endmodule

`default_nettype wire

FILE: sv/pirc_back.sv
`default_nettype none

module pirc_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           polygon_type_i,
  input  wire logic           req_valid_i,
  input  wire pirc_pkg::edge_req_t req_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic                inside_res_o
);

  localparam int unsigned R = pirc_pkg::REL_W;
  localparam int unsigned P = pirc_pkg::PROD_W;

  logic                    advance;
  logic signed [R-1:0]     x1, y1, x2, y2;
  logic signed [P-1:0]     p_d, q_d, p_q, q_q;
  logic                    b1_v_q, b1_v_d;
  pirc_pkg::edge_cls_e     cls_q;
  logic                    dy_pos_q, last_q;
  logic [P:0]              diff;
  logic                    cs_pos, cs_neg, edge_hit;
  logic                    parity_q, parity_d;
  logic                    out_valid_q, out_valid_d;
  logic                    inside_q, inside_d;

  assign advance = !out_valid_q || out_ready_i;
  assign pop_o   = advance && req_valid_i;
  assign b1_v_d  = req_valid_i;

  assign x1  = req_i.x1;
  assign y1  = req_i.y1;
  assign x2  = req_i.x2;
  assign y2  = req_i.y2;
  assign p_d = x1 * y2;
  assign q_d = x2 * y1;

  assign diff   = {p_q[P-1], p_q} - {q_q[P-1], q_q};
  assign cs_neg = diff[P];
  assign cs_pos = !diff[P] && (diff != '0);

  always_comb begin
    unique case (cls_q)
      pirc_pkg::CLS_FIRST: edge_hit = 1'b0;
      pirc_pkg::CLS_NONE:  edge_hit = 1'b0;
      pirc_pkg::CLS_CROSS: edge_hit = 1'b1;
      pirc_pkg::CLS_TEST:  edge_hit = (cs_pos && dy_pos_q) || (cs_neg && !dy_pos_q);
      default:             edge_hit = 1'b0;
    endcase
  end

  always_comb begin
    parity_d    = parity_q;
    out_valid_d = out_valid_q;
    inside_d    = inside_q;
    if (advance) begin
      out_valid_d = b1_v_q && last_q;
      if (b1_v_q) begin
        parity_d = (cls_q == pirc_pkg::CLS_FIRST) ? 1'b0 : (parity_q ^ edge_hit);
        inside_d = parity_d & polygon_type_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      p_q      <= p_d;
      q_q      <= q_d;
      cls_q    <= req_i.cls;
      dy_pos_q <= req_i.dy_pos;
      last_q   <= req_i.last;
    end
    inside_q <= inside_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q      <= 1'b0;
      parity_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        b1_v_q <= b1_v_d;
      end
      parity_q    <= parity_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;

`ifndef ASSERT_OFF
  a_first_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && b1_v_q && (cls_q == pirc_pkg::CLS_FIRST)) |=> !parity_q)
    else $error("ring start did not clear parity");
  a_not_polygon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && b1_v_q && last_q && !polygon_type_i) |=> !inside_res_o)
    else $error("inside reported for non-polygon shape");
`endif

endmodule

`default_nettype wire

FILE: sv/point_in_ring_crossing.sv
// Path: a closing vertex is held in the queue, then in the registered product stage,
//   then in the output register; requests queued ahead of it delay its result.
// Throughput: one vertex per cycle unless the queue is full or a result waits;
//   combinational sign classifier, registered product and subtract-compare stages.
// Reset: rst_ni clears ring state, parity, queue and output valid; polygon_type is 1.
`default_nettype none

module point_in_ring_crossing (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    in_valid_i,
  output logic                                         in_ready_o,
  input  wire logic signed [pirc_pkg::COORD_WIDTH-1:0] vertex_x_i,
  input  wire logic signed [pirc_pkg::COORD_WIDTH-1:0] vertex_y_i,
  input  wire logic signed [pirc_pkg::COORD_WIDTH-1:0] query_x_i,
  input  wire logic signed [pirc_pkg::COORD_WIDTH-1:0] query_y_i,
  input  wire logic                                    first_vertex_i,
  input  wire logic                                    last_vertex_i,
  output logic                                         out_valid_o,
  input  wire logic                                    out_ready_i,
  output logic                                         inside_res_o,
  input  wire logic                                    cfg_we_i,
  input  wire logic                                    cfg_wdata_i
);

  logic                polygon_type_q;
  logic                accept;
  logic                push, full, pop, req_valid;
  pirc_pkg::edge_req_t push_req, pop_req;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      polygon_type_q <= 1'b1;
    end else if (cfg_we_i) begin
      polygon_type_q <= cfg_wdata_i;
    end
  end

  pirc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .vertex_x_i     (vertex_x_i),
    .vertex_y_i     (vertex_y_i),
    .query_x_i      (query_x_i),
    .query_y_i      (query_y_i),
    .first_vertex_i (first_vertex_i),
    .last_vertex_i  (last_vertex_i),
    .push_o         (push),
    .push_req_o     (push_req)
  );

  pirc_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_req_i (push_req),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (req_valid),
    .pop_req_o  (pop_req)
  );

  pirc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .polygon_type_i (polygon_type_q),
    .req_valid_i    (req_valid),
    .req_i          (pop_req),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .inside_res_o   (inside_res_o)
  );

endmodule

`default_nettype wire
